// ===== rtl/utf8dc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package utf8dc_pkg;

  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int CLASS_W     = 6;
  localparam int CP_W        = 21;
  localparam int LINE_NUM_W  = 24;
  localparam int SEQ_LEN_W   = 3;
  localparam int PEND_W      = 2;
  localparam int LINE_BITS_DEF = 24;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [CLASS_W-1:0] CLS_BREAK = 6'd0;
  localparam logic [CLASS_W-1:0] CLS_SPACE = 6'd1;
  localparam logic [CLASS_W-1:0] CLS_DIGIT = 6'd34;
  localparam logic [CLASS_W-1:0] CLS_UPPER = 6'd35;
  localparam logic [CLASS_W-1:0] CLS_LOWER = 6'd36;
  localparam logic [CLASS_W-1:0] CLS_OTHER = 6'd37;

  // Break and space characters report a plain space.
  localparam logic [CP_W-1:0] CP_BLANK = 21'h20;
  localparam logic [CP_W-1:0] CP_LF    = 21'h0A;

endpackage : utf8dc_pkg

`default_nettype wire

// ===== rtl/utf8_char_decode_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                  | Dir | Beat
// ---------+----------------------------------------+-----+----------------------------
// input    | in_valid in_ready in_byte_value        | in  | one source byte or end mark
//          | in_end_of_input                        |     |
// result   | out_valid out_ready out_result_kind    | out | char, end or coding error
//          | out_char_class out_code_point          |     |
//          | out_line_number out_seq_length         |     |
//
// One byte per cycle sustained while out_ready keeps the result register free. A beat
// is decoded and classified while it sits in the input register and then lands in the
// result register, whose valid flag drives out_valid. Reset (rst_n low, synchronous)
// clears decoder state, the line counter and both valid flags. A stalled result
// register holds the input register, and in_ready drops only while both hold.

module utf8_char_decode_classify import utf8dc_pkg::*; #(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_byte_value,
  input  logic                  in_end_of_input,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_result_kind,
  output logic [CLASS_W-1:0]    out_char_class,
  output logic [CP_W-1:0]       out_code_point,
  output logic [LINE_NUM_W-1:0] out_line_number,
  output logic [SEQ_LEN_W-1:0]  out_seq_length
);

  // input register
  logic              s1_vld_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_end_r;

  // decoder state
  logic [PEND_W-1:0]    pend_r, pend_nxt;
  logic [CP_W-1:0]      acc_r, acc_nxt;
  logic [SEQ_LEN_W-1:0] taken_r, taken_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  // result register
  logic                 out_vld_r;
  kind_t                kind_r;
  logic [CLASS_W-1:0]   cls_r;
  logic [CP_W-1:0]      cp_r;
  logic [LINE_BITS-1:0] line_out_r;
  logic [SEQ_LEN_W-1:0] len_r;

  logic                 out_free;
  logic                 proc_en;
  logic                 res_vld;
  logic                 char_vld;
  kind_t                res_kind;
  logic [CP_W-1:0]      raw_cp;
  logic [SEQ_LEN_W-1:0] res_len;
  logic [CP_W-1:0]      acc_cat;
  logic [CLASS_W-1:0]   raw_cls;
  logic [CLASS_W-1:0]   res_cls;
  logic [CP_W-1:0]      res_cp;

  assign out_free = !out_vld_r || out_ready;
  assign proc_en  = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || proc_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_value;
      s1_end_r  <= in_end_of_input;
    end
  end

  assign acc_cat = {acc_r[CP_W-7:0], s1_byte_r[5:0]};

  always_comb begin
    res_vld   = 1'b0;
    char_vld  = 1'b0;
    res_kind  = KIND_CHAR;
    raw_cp    = '0;
    res_len   = '0;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    taken_nxt = taken_r;
    if (pend_r != '0) begin
      priority if (s1_end_r) begin
        res_vld   = 1'b1;
        res_kind  = KIND_ERROR;
        res_len   = taken_r;
        pend_nxt  = '0;
        acc_nxt   = '0;
        taken_nxt = '0;
      end else if (s1_byte_r[7:6] != 2'b10) begin
        // bad continuation is consumed into the error
        res_vld   = 1'b1;
        res_kind  = KIND_ERROR;
        res_len   = taken_r + 3'd1;
        pend_nxt  = '0;
        acc_nxt   = '0;
        taken_nxt = '0;
      end else if (pend_r == 2'd1) begin
        res_vld   = 1'b1;
        char_vld  = 1'b1;
        raw_cp    = acc_cat;
        res_len   = taken_r + 3'd1;
        pend_nxt  = '0;
        acc_nxt   = '0;
        taken_nxt = '0;
      end else begin
        acc_nxt   = acc_cat;
        taken_nxt = taken_r + 3'd1;
        pend_nxt  = pend_r - 2'd1;
      end
    end else begin
      priority if (s1_end_r) begin
        res_vld  = 1'b1;
        res_kind = KIND_END;
      end else if (!s1_byte_r[7]) begin
        res_vld  = 1'b1;
        char_vld = 1'b1;
        raw_cp   = CP_W'(s1_byte_r);
        res_len  = 3'd1;
      end else if (s1_byte_r[7:6] == 2'b10) begin
        res_vld  = 1'b1;
        res_kind = KIND_ERROR;
        res_len  = 3'd1;
      end else if (s1_byte_r[7:5] == 3'b110) begin
        acc_nxt   = CP_W'(s1_byte_r[4:0]);
        pend_nxt  = 2'd1;
        taken_nxt = 3'd1;
      end else if (s1_byte_r[7:4] == 4'b1110) begin
        acc_nxt   = CP_W'(s1_byte_r[3:0]);
        pend_nxt  = 2'd2;
        taken_nxt = 3'd1;
      end else if (s1_byte_r[7:3] == 5'b11110) begin
        acc_nxt   = CP_W'(s1_byte_r[2:0]);
        pend_nxt  = 2'd3;
        taken_nxt = 3'd1;
      end else begin
        // five to seven byte leads, 0xFE and 0xFF
        res_vld  = 1'b1;
        res_kind = KIND_ERROR;
        res_len  = 3'd1;
      end
    end
  end

  utf8dc_class u_class (
    .code_point (raw_cp),
    .char_class (raw_cls)
  );

  always_comb begin
    res_cls = '0;
    res_cp  = '0;
    if (char_vld) begin
      res_cls = raw_cls;
      res_cp  = (raw_cls == CLS_BREAK || raw_cls == CLS_SPACE) ? CP_BLANK : raw_cp;
    end
  end

  // saturate at all ones
  always_comb begin
    line_nxt = line_r;
    if (char_vld && raw_cp == CP_LF && line_r != '1) begin
      line_nxt = line_r + LINE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      acc_r   <= '0;
      taken_r <= '0;
      line_r  <= '0;
    end else if (proc_en) begin
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
      taken_r <= taken_nxt;
      line_r  <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= proc_en && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && res_vld) begin
      kind_r     <= res_kind;
      cls_r      <= res_cls;
      cp_r       <= res_cp;
      line_out_r <= line_nxt;
      len_r      <= res_len;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_kind = kind_r;
  assign out_char_class  = cls_r;
  assign out_code_point  = cp_r;
  assign out_line_number = LINE_NUM_W'(line_out_r);
  assign out_seq_length  = len_r;

endmodule : utf8_char_decode_classify

`default_nettype wire

// ===== rtl/utf8dc_class.sv =====
`timescale 1ns / 1ps
`default_nettype none

module utf8dc_class import utf8dc_pkg::*; (
  input  logic [CP_W-1:0]    code_point,
  output logic [CLASS_W-1:0] char_class
);

  logic [6:0] lo;
  logic       ascii;

  assign lo    = code_point[6:0];
  assign ascii = (code_point[CP_W-1:7] == '0);

  // Punctuation classes run 2..33 in ASCII order across four ranges;
  // each arm subtracts the offset that maps the range start onto its class.
  always_comb begin
    priority if (!ascii) begin
      char_class = CLS_OTHER;
    end else if (lo == 7'h0A || lo == 7'h0D) begin
      char_class = CLS_BREAK;
    end else if (lo == 7'h09 || lo == 7'h20) begin
      char_class = CLS_SPACE;
    end else if (lo >= 7'h21 && lo <= 7'h2F) begin
      char_class = CLASS_W'(lo - 7'h1F);
    end else if (lo >= 7'h3A && lo <= 7'h40) begin
      char_class = CLASS_W'(lo - 7'h29);
    end else if (lo >= 7'h5B && lo <= 7'h60) begin
      char_class = CLASS_W'(lo - 7'h43);
    end else if (lo >= 7'h7B && lo <= 7'h7E) begin
      char_class = CLASS_W'(lo - 7'h5D);
    end else if (lo >= 7'h30 && lo <= 7'h39) begin
      char_class = CLS_DIGIT;
    end else if (lo >= 7'h41 && lo <= 7'h5A) begin
      char_class = CLS_UPPER;
    end else if (lo >= 7'h61 && lo <= 7'h7A) begin
      char_class = CLS_LOWER;
    end else begin
      char_class = CLS_OTHER;
    end
  end

endmodule : utf8dc_class

`default_nettype wire
